// ===== sv/http_response_keepalive_check_assert.svh =====
// Assertion macros for the keep-alive checker; empty when SYNTH is defined.
`ifndef HTTP_RESPONSE_KEEPALIVE_CHECK_ASSERT_SVH
`define HTTP_RESPONSE_KEEPALIVE_CHECK_ASSERT_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define HRKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define HRKC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HRKC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HRKC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/hrkc_pkg.sv =====
// Shared types, match tables and helpers for the keep-alive checker.
package hrkc_pkg;

    // One input request as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       keepalive_allowed;
    } hrkc_req_t;

    // Verdict for one response
    typedef struct packed {
        logic parse_error;
        logic keep_alive;
        logic chunk_insert;
    } hrkc_result_t;

    localparam int NUM_HDR  = 4;
    localparam int NAME_MAX = 17;

    // Header name indexes
    localparam logic [1:0] HDR_CONNECTION = 2'd0;
    localparam logic [1:0] HDR_TRAILERS   = 2'd1;
    localparam logic [1:0] HDR_CLEN       = 2'd2;
    localparam logic [1:0] HDR_TENC       = 2'd3;

    localparam logic [4:0] HDR_LEN [NUM_HDR] = '{5'd10, 5'd8, 5'd14, 5'd17};

    localparam logic [7:0] TOK_HTTP [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

    localparam logic [7:0] VAL_CLOSE [5] = '{"c", "l", "o", "s", "e"};

    localparam logic [7:0] NAME_CHARS [NUM_HDR][NAME_MAX] = '{
        '{"c", "o", "n", "n", "e", "c", "t", "i", "o", "n",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "r", "a", "i", "l", "e", "r", "s",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h",
          8'h00, 8'h00, 8'h00},
        '{"t", "r", "a", "n", "s", "f", "e", "r", "-", "e", "n", "c", "o", "d",
          "i", "n", "g"}
    };

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // ASCII lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Header name character; zero past the longest name
    function automatic logic [7:0] name_char(input logic [1:0] j, input logic [4:0] pos);
        if (pos > 5'd16)
        begin
            return 8'h00;
        end
        return NAME_CHARS[j][pos];
    endfunction

    // "close" character at a value offset; zero outside the word
    function automatic logic [7:0] close_char(input logic [2:0] pos);
        if (pos > 3'd4)
        begin
            return 8'h00;
        end
        return VAL_CLOSE[pos];
    endfunction

endpackage

// ===== sv/hrkc_in_reg.sv =====
// Input register: holds one request until the scanner consumes it.
module hrkc_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hrkc_pkg::hrkc_req_t in_req,
    input  logic               take,
    output logic               req_valid,
    output hrkc_pkg::hrkc_req_t req
);
    import hrkc_pkg::*;

    logic      valid_reg;
    hrkc_req_t req_reg;

    // free when empty or being drained this cycle
    assign in_ready  = !valid_reg || take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= in_req;
        end
    end

endmodule

// ===== sv/hrkc_scan.sv =====
// Header scanner: per-byte parse state and the verdict on the last byte.
module hrkc_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  step,
    input  hrkc_pkg::hrkc_req_t   req,
    output hrkc_pkg::hrkc_result_t result
);
    import hrkc_pkg::*;

    typedef enum logic [2:0] {
        PH_PROTO,
        PH_STATUS,
        PH_SEEK,
        PH_LINE,
        PH_DONE,
        PH_ERROR,
        PH_BETWEEN
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [4:0] name_pos;
        logic [4:0] cand;       // [3:0] names still matching, [4] no colon yet
        logic [2:0] value_pos;
        logic       value_close;
        logic       ka_flag;
        logic       size_seen;
        logic       err_flag;
        logic [7:0] prev_byte;
    } scan_t;

    localparam scan_t SCAN_CLEAR = '{
        phase:       PH_PROTO,
        name_pos:    5'd0,
        cand:        5'h1F,
        value_pos:   3'd0,
        value_close: 1'b1,
        ka_flag:     1'b0,
        size_seen:   1'b0,
        err_flag:    1'b0,
        prev_byte:   8'h00
    };

    scan_t scan_reg;
    scan_t scan_next;
    logic  auto_chunk_reg;

    // one byte of a header line: name match before the colon, value after
    function automatic scan_t line_byte(input scan_t s, input logic [7:0] b);
        logic [7:0] lb;
        lb = to_lower(b);
        if (s.cand[4])
        begin
            if (b == CH_COLON)
            begin
                s.cand[4] = 1'b0;
                for (int j = 0; j < NUM_HDR; j++)
                begin
                    if (s.name_pos != HDR_LEN[j])
                    begin
                        s.cand[j] = 1'b0;
                    end
                end
                s.value_pos   = 3'd0;
                s.value_close = 1'b1;
            end
            else
            begin
                for (int j = 0; j < NUM_HDR; j++)
                begin
                    if (s.name_pos >= HDR_LEN[j] || lb != name_char(2'(j), s.name_pos))
                    begin
                        s.cand[j] = 1'b0;
                    end
                end
                if (s.name_pos != 5'd31)
                begin
                    s.name_pos = s.name_pos + 5'd1;
                end
            end
        end
        else
        begin
            if (s.value_pos >= 3'd1 && s.value_pos <= 3'd5 &&
                lb != close_char(s.value_pos - 3'd1))
            begin
                s.value_close = 1'b0;
            end
            if (s.value_pos != 3'd7)
            begin
                s.value_pos = s.value_pos + 3'd1;
            end
        end
        return s;
    endfunction

    // next state and verdict for the byte in the input register
    always_comb
    begin
        scan_t      s;
        logic [7:0] b;
        logic       eol;
        logic       tok_match;

        s         = scan_reg;
        b         = req.data_byte;
        eol       = (b == CH_CR) || (b == CH_LF);
        tok_match = 1'b0;
        result    = '0;

        if (req.first_byte)
        begin
            s         = SCAN_CLEAR;
            s.ka_flag = req.keepalive_allowed;
        end

        case (s.phase)
            PH_PROTO:
            begin
                if (b == CH_SPACE)
                begin
                    tok_match = s.cand[0] && (s.name_pos == 5'd8);
                    if (s.ka_flag && !tok_match)
                    begin
                        s.ka_flag = 1'b0;
                        s.phase   = PH_DONE;
                    end
                    else if (req.last_byte)
                    begin
                        s.err_flag = 1'b1;
                        s.phase    = PH_ERROR;
                    end
                    else
                    begin
                        s.phase = PH_STATUS;
                    end
                end
                else
                begin
                    if (s.name_pos >= 5'd8 || b != TOK_HTTP[s.name_pos[2:0]])
                    begin
                        s.cand[0] = 1'b0;
                    end
                    if (s.name_pos != 5'd31)
                    begin
                        s.name_pos = s.name_pos + 5'd1;
                    end
                end
            end
            PH_STATUS:
            begin
                if (eol)
                begin
                    if (req.last_byte)
                    begin
                        s.err_flag = 1'b1;
                        s.phase    = PH_ERROR;
                    end
                    else
                    begin
                        s.phase = PH_SEEK;
                    end
                end
            end
            PH_SEEK, PH_BETWEEN:
            begin
                if (!eol)
                begin
                    s.name_pos    = 5'd0;
                    s.cand        = 5'h1F;
                    s.value_pos   = 3'd0;
                    s.value_close = 1'b1;
                    s.phase       = PH_LINE;
                    s             = line_byte(s, b);
                end
            end
            PH_LINE:
            begin
                if (!eol)
                begin
                    s = line_byte(s, b);
                end
                else if (s.cand[4] || (s.value_pos == 3'd0 && req.last_byte))
                begin
                    // no colon, or colon right before a closing line end
                    s.err_flag = 1'b1;
                    s.phase    = PH_ERROR;
                end
                else
                begin
                    s.phase = PH_BETWEEN;
                    if (s.ka_flag)
                    begin
                        if (s.cand[HDR_CONNECTION])
                        begin
                            if (s.value_pos == 3'd6 && s.value_close)
                            begin
                                s.ka_flag = 1'b0;
                                s.phase   = PH_DONE;
                            end
                        end
                        else if (s.cand[HDR_TRAILERS])
                        begin
                            s.ka_flag = 1'b0;
                            s.phase   = PH_DONE;
                        end
                        else if (s.cand[HDR_CLEN] || s.cand[HDR_TENC])
                        begin
                            s.size_seen = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // verdict
        if (s.err_flag || s.phase == PH_ERROR)
        begin
            result.parse_error = 1'b1;
        end
        else if (s.phase == PH_LINE || s.phase == PH_BETWEEN)
        begin
            if (s.ka_flag && !s.size_seen)
            begin
                if (auto_chunk_reg && s.prev_byte == CH_CR && b == CH_LF)
                begin
                    result.keep_alive   = 1'b1;
                    result.chunk_insert = 1'b1;
                end
            end
            else
            begin
                result.keep_alive = s.ka_flag;
            end
        end

        if (req.last_byte)
        begin
            scan_next = SCAN_CLEAR;
        end
        else
        begin
            scan_next           = s;
            scan_next.prev_byte = b;
        end
    end

    // parse state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= SCAN_CLEAR;
            auto_chunk_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                scan_reg <= scan_next;
            end
            if (cfg_wr_en)
            begin
                auto_chunk_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== sv/hrkc_out_reg.sv =====
// Output register: holds one verdict until the receiver takes it.
module hrkc_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  hrkc_pkg::hrkc_result_t res_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   busy,
    output hrkc_pkg::hrkc_result_t res_out
);
    import hrkc_pkg::*;

    logic         valid_reg;
    hrkc_result_t res_reg;

    assign out_valid = valid_reg;
    assign res_out   = res_reg;
    // cannot take a new verdict this cycle
    assign busy      = valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

// ===== sv/http_response_keepalive_check.sv =====
// Top level of the HTTP response keep-alive checker.
//
// Input channel (in_valid / in_ready) carries one header byte per request
// with first_byte / last_byte framing and keepalive_allowed, sampled with
// first_byte. Output channel (out_valid / out_ready) carries one verdict
// per response, produced only for the request marked last_byte.
// cfg_wr_en / cfg_wr_data write auto_chunk_enable; write only while idle.
//
// A byte is registered in the input register on acceptance and scanned
// from there; the verdict for the last byte is registered in the output
// register when that byte is scanned.
// Throughput: one byte per cycle through the combinational scan step
// between the input register and the parse state registers, while no final byte waits.
// When the receiver stalls, the verdict waits in the output register;
// non-final bytes keep flowing, and a second final byte waits in the
// input register, which then drops in_ready.
// Reset clears the parse state, the configuration bit and both
// valid flags; the next byte opens a response with keep-alive off
// unless it carries first_byte.
`include "http_response_keepalive_check_assert.svh"

module http_response_keepalive_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       keepalive_allowed,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       parse_error,
    output logic       keep_alive,
    output logic       chunk_insert
);
    import hrkc_pkg::*;

    hrkc_req_t    in_req;
    hrkc_req_t    req;
    logic         req_valid;
    logic         take;
    logic         load;
    logic         busy;
    hrkc_result_t result;
    hrkc_result_t res_out;

    assign in_req.data_byte         = data_byte;
    assign in_req.first_byte        = first_byte;
    assign in_req.last_byte         = last_byte;
    assign in_req.keepalive_allowed = keepalive_allowed;

    // scan a byte unless it ends a response and the output is occupied
    assign take = req_valid && (!req.last_byte || !busy);
    assign load = take && req.last_byte;

    hrkc_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .take      (take),
        .req_valid (req_valid),
        .req       (req)
    );

    hrkc_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .req         (req),
        .result      (result)
    );

    hrkc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res_in    (result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .busy      (busy),
        .res_out   (res_out)
    );

    assign parse_error  = res_out.parse_error;
    assign keep_alive   = res_out.keep_alive;
    assign chunk_insert = res_out.chunk_insert;

    // checks
    `HRKC_ASSERT_IMP(a_chunk_ka, clk, rst_n, out_valid && chunk_insert, keep_alive && !parse_error)
    `HRKC_ASSERT_IMP(a_error_no_ka, clk, rst_n, out_valid && parse_error, !keep_alive && !chunk_insert)
    `HRKC_ASSERT_IMP(a_no_overwrite, clk, rst_n, load, !busy)
    `HRKC_ASSERT_NXT(a_load_shows, clk, rst_n, load, out_valid)

endmodule
